FILE: hw/rtl/s4p_pkg.sv
// ----------------------------------------------------------------------------
// s4p_pkg
// Shared types and constants for the SOCKS4a request parser.
// ----------------------------------------------------------------------------
package s4p_pkg;

  // Protocol constants
  localparam logic [7:0] SOCKS_VERSION     = 8'h04;
  localparam logic [7:0] SOCKS_CMD_CONNECT = 8'h01;
  localparam logic [7:0] NAME_TERM         = 8'h00;

  // Register reset value
  localparam logic [7:0] MAX_NAME_LEN_RST  = 8'd255;

  // Result kinds
  localparam logic [2:0] KIND_NAME        = 3'd0;
  localparam logic [2:0] KIND_DONE        = 3'd1;
  localparam logic [2:0] KIND_BAD_VERSION = 3'd2;
  localparam logic [2:0] KIND_BAD_COMMAND = 3'd3;
  localparam logic [2:0] KIND_TOO_LONG    = 3'd4;

  // One result item plus its emit flag
  typedef struct packed {
    logic        emit;
    logic [2:0]  kind;
    logic [7:0]  name_byte;
    logic [15:0] port;
    logic [31:0] addr;
  } result_t;

endpackage

FILE: hw/rtl/socks4a_request_parser_core.sv
// ----------------------------------------------------------------------------
// socks4a_request_parser_core
// SOCKS4a request header parser, one request byte per item.
//
// Input channel (in_valid, in_stall, data_byte) carries the client's request
// stream. Output channel (out_valid, out_stall, result_kind, name_byte,
// dest_port, dest_addr) carries domain bytes, a done item with port and
// address, or an error item (bad version, bad command, name too long).
// Bytes that produce nothing (command, port, address, user id) are consumed
// silently. The cfg channel writes max_name_len; cfg_ready is always high.
// An accepted byte is captured in the input register, and its result then in
// the result register. Throughput: one byte per cycle while the receiver does
// not stall, set by the combinational parse step between the two registers.
// When the receiver stalls, the result register holds and the held input
// byte waits; in_stall rises only while both are occupied.
// Reset (rst, synchronous) empties both registers, returns the parser to
// expecting a version byte and sets max_name_len to 255.
// ----------------------------------------------------------------------------
module socks4a_request_parser_core import s4p_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  result_kind,
  output logic [7:0]  name_byte,
  output logic [15:0] dest_port,
  output logic [31:0] dest_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       out_free;
  logic       advance;
  result_t    res;

  assign cfg_ready = 1'b1;
  assign advance   = held_valid && out_free;

  s4p_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  s4p_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .byte_in  (held_byte),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .res      (res)
  );

  s4p_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .res         (res),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .name_byte   (name_byte),
    .dest_port   (dest_port),
    .dest_addr   (dest_addr)
  );

endmodule

FILE: hw/rtl/s4p_in_reg.sv
// ----------------------------------------------------------------------------
// s4p_in_reg
// Input register: holds one request byte until the parser consumes it.
// ----------------------------------------------------------------------------
module s4p_in_reg import s4p_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic accept;

  // Stall while a held item cannot move on
  assign in_stall = held_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Load a new item, drop the held one once consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= accept || (held_valid && !advance);
    end
    if (accept) begin
      held_byte <= data_byte;
    end
  end

endmodule

FILE: hw/rtl/s4p_parser.sv
// ----------------------------------------------------------------------------
// s4p_parser
// Header walker: one byte per step, updates parse state and forms a result.
// ----------------------------------------------------------------------------
module s4p_parser import s4p_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] byte_in,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  output result_t    res
);

  typedef enum logic [2:0] {
    PH_VERSION = 3'd0,
    PH_COMMAND = 3'd1,
    PH_PORT    = 3'd2,
    PH_ADDR    = 3'd3,
    PH_USER    = 3'd4,
    PH_DOMAIN  = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [15:0] port_reg, port_reg_next;
  logic [31:0] addr_reg, addr_reg_next;
  logic [7:0]  name_count, name_count_next;
  logic [7:0]  max_name_len;
  logic        at_limit;

  assign at_limit = name_count >= max_name_len;

  // Next state and result for the current byte
  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    port_reg_next   = port_reg;
    addr_reg_next   = addr_reg;
    name_count_next = name_count;
    res             = '0;
    case (phase)
      PH_COMMAND: begin
        if (byte_in != SOCKS_CMD_CONNECT) begin
          phase_next      = PH_VERSION;
          byte_index_next = '0;
          port_reg_next   = '0;
          addr_reg_next   = '0;
          name_count_next = '0;
          res.emit        = 1'b1;
          res.kind        = KIND_BAD_COMMAND;
        end else begin
          phase_next      = PH_PORT;
          byte_index_next = '0;
        end
      end
      PH_PORT: begin
        port_reg_next = {port_reg[7:0], byte_in};
        if (byte_index >= 2'd1) begin
          byte_index_next = '0;
          phase_next      = PH_ADDR;
        end else begin
          byte_index_next = byte_index + 2'd1;
        end
      end
      PH_ADDR: begin
        addr_reg_next = {addr_reg[23:0], byte_in};
        if (byte_index == 2'd3) begin
          byte_index_next = '0;
          name_count_next = '0;
          phase_next      = PH_USER;
        end else begin
          byte_index_next = byte_index + 2'd1;
        end
      end
      PH_USER, PH_DOMAIN: begin
        if (byte_in == NAME_TERM) begin
          name_count_next = '0;
          if (phase == PH_USER) begin
            phase_next = PH_DOMAIN;
          end else begin
            phase_next      = PH_VERSION;
            byte_index_next = '0;
            port_reg_next   = '0;
            addr_reg_next   = '0;
            res.emit        = 1'b1;
            res.kind        = KIND_DONE;
            res.port        = port_reg;
            res.addr        = addr_reg;
          end
        end else if (at_limit) begin
          phase_next      = PH_VERSION;
          byte_index_next = '0;
          port_reg_next   = '0;
          addr_reg_next   = '0;
          name_count_next = '0;
          res.emit        = 1'b1;
          res.kind        = KIND_TOO_LONG;
        end else begin
          name_count_next = name_count + 8'd1;
          if (phase == PH_DOMAIN) begin
            res.emit      = 1'b1;
            res.kind      = KIND_NAME;
            res.name_byte = byte_in;
          end
        end
      end
      default: begin
        // Idle: expect the version byte
        byte_index_next = '0;
        port_reg_next   = '0;
        addr_reg_next   = '0;
        name_count_next = '0;
        if (byte_in != SOCKS_VERSION) begin
          phase_next = PH_VERSION;
          res.emit   = 1'b1;
          res.kind   = KIND_BAD_VERSION;
        end else begin
          phase_next = PH_COMMAND;
        end
      end
    endcase
  end

  // Hold parse state and the limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_VERSION;
      byte_index   <= '0;
      port_reg     <= '0;
      addr_reg     <= '0;
      name_count   <= '0;
      max_name_len <= MAX_NAME_LEN_RST;
    end else begin
      if (step) begin
        phase      <= phase_next;
        byte_index <= byte_index_next;
        port_reg   <= port_reg_next;
        addr_reg   <= addr_reg_next;
        name_count <= name_count_next;
      end
      if (cfg_we) begin
        max_name_len <= cfg_data;
      end
    end
  end

endmodule

FILE: hw/rtl/s4p_out_reg.sv
// ----------------------------------------------------------------------------
// s4p_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module s4p_out_reg import s4p_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  result_t     res,
  output logic        out_free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  result_kind,
  output logic [7:0]  name_byte,
  output logic [15:0] dest_port,
  output logic [31:0] dest_addr
);

  // Free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  // Load on a step that emits, clear once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && res.emit) begin
      result_kind <= res.kind;
      name_byte   <= res.name_byte;
      dest_port   <= res.port;
      dest_addr   <= res.addr;
    end
  end

endmodule

FILE: hw/rtl/s4p_checker.sv
// ----------------------------------------------------------------------------
// s4p_checker
// Port-level checks for the SOCKS4a request parser, bound to the top level.
// ----------------------------------------------------------------------------
module s4p_checker import s4p_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  result_kind,
  input logic [7:0]  name_byte,
  input logic [15:0] dest_port,
  input logic [31:0] dest_addr
);

  // Results are empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind) &&
      $stable(name_byte) && $stable(dest_port) && $stable(dest_addr))
    else $error("stalled result changed");

  // Kind code is always a defined one
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_kind <= KIND_TOO_LONG)
    else $error("undefined result kind");

  // Name byte is zero outside domain-byte items
  a_name_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != KIND_NAME |-> name_byte == 8'd0)
    else $error("name byte set on non-name item");

  // Port and address are zero outside done items
  a_dest_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != KIND_DONE |-> dest_port == 16'd0 && dest_addr == 32'd0)
    else $error("destination set on non-done item");

endmodule

bind socks4a_request_parser_core s4p_checker u_s4p_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_kind (result_kind),
  .name_byte   (name_byte),
  .dest_port   (dest_port),
  .dest_addr   (dest_addr)
);
